// ----- hdl/mbps_pkg.sv -----
package mbps_pkg;

   // Default sizing, handed down from the top level
   localparam int PATTERN_BYTES_DEF = 16;
   localparam int OFFSET_BITS_DEF   = 32;

   // Fixed field widths
   localparam int BYTE_BITS       = 8;
   localparam int MATCH_OFS_BITS  = 32;
   localparam int LENGTH_BITS     = 5;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 64;
   localparam int PATTERN_MAX     = 16;
   localparam int PATTERN_WORD    = PATTERN_MAX * BYTE_BITS;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_VALUE_LOW  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_VALUE_HIGH = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MASK_LOW   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MASK_HIGH  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LENGTH     = 3'd4;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic                 last_byte;
   } req_type;

   typedef struct packed {
      logic                      found;
      logic [MATCH_OFS_BITS-1:0] match_offset;
   } rsp_type;

   // Pattern set-up as seen by the compare logic
   typedef struct packed {
      logic [PATTERN_WORD-1:0] value;
      logic [PATTERN_WORD-1:0] mask;
      logic [LENGTH_BITS-1:0]  length;
   } pattern_type;

endpackage

// ----- hdl/mbps_window_match.sv -----
module mbps_window_match #(
   parameter int PATTERN_BYTES = mbps_pkg::PATTERN_BYTES_DEF
) (
   input  logic [mbps_pkg::BYTE_BITS-1:0] window_bytes [PATTERN_BYTES],
   input  mbps_pkg::pattern_type           pattern,
   output logic                            hit
);

   localparam int IDX_BITS = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
   localparam int LB       = mbps_pkg::LENGTH_BITS;
   localparam int BB       = mbps_pkg::BYTE_BITS;

   logic [PATTERN_BYTES-1:0] byte_ok;

   // Pattern byte i lines up with window slot length-1-i (newest at slot 0)
   always_comb begin
      logic [LB-1:0]       slot;
      logic [BB-1:0]       pat_v;
      logic [BB-1:0]       pat_m;
      logic [BB-1:0]       data;
      for (int i = 0; i < PATTERN_BYTES; i++) begin
         slot  = LB'(pattern.length - LB'(i + 1));
         pat_v = pattern.value[BB*i +: BB];
         pat_m = pattern.mask[BB*i +: BB];
         data  = window_bytes[slot[IDX_BITS-1:0]];
         if (LB'(i) >= pattern.length) begin
            byte_ok[i] = 1'b1;
         end else begin
            byte_ok[i] = ((data & pat_m) == (pat_v & pat_m));
         end
      end
   end

   // Zero length and over-long patterns never match
   assign hit = (pattern.length != '0) &&
                (pattern.length <= LB'(PATTERN_BYTES)) &&
                (&byte_ok);

endmodule

// ----- hdl/masked_byte_pattern_search_core.sv -----
// Masked byte pattern search. One region byte is taken per req_ transaction, and a
// new byte can be taken every clock cycle while req_stall is low. The core keeps a
// window of the latest PATTERN_BYTES bytes and compares every pattern byte, under
// its care mask, in parallel as the byte arrives; the result of that byte is in the
// rsp_ register in the cycle after acceptance. Each region gives exactly one rsp_
// transaction: found with the start offset at the first match, or not found at the
// byte marked last_byte. req_stall is high only while a result waits in the output
// register and rsp_stall is high. Pattern registers are written through the csr_
// port, which is always ready, and must only be changed while the core is idle.
module masked_byte_pattern_search_core #(
   parameter int PATTERN_BYTES = mbps_pkg::PATTERN_BYTES_DEF,
   parameter int OFFSET_BITS   = mbps_pkg::OFFSET_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  mbps_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output mbps_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mbps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mbps_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int BB  = mbps_pkg::BYTE_BITS;
   localparam int LB  = mbps_pkg::LENGTH_BITS;
   localparam int OB  = mbps_pkg::MATCH_OFS_BITS;
   localparam int DB  = mbps_pkg::CSR_DATA_BITS;

   // Configuration registers
   logic [DB-1:0] value_low_ff, value_high_ff, mask_low_ff, mask_high_ff;
   logic [LB-1:0] length_ff;

   // Region state
   logic [BB-1:0]          window_ff [PATTERN_BYTES];
   logic [BB-1:0]          window_in [PATTERN_BYTES];
   logic [OFFSET_BITS-1:0] seen_ff, seen_in;
   logic                   found_ff, found_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   mbps_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   hit;
   logic [OFFSET_BITS-1:0] total;
   logic [OFFSET_BITS-1:0] start;
   logic [OFFSET_BITS+OB-1:0] start_wide;
   mbps_pkg::pattern_type  pattern;

   assign csr_ready = 1'b1;

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         value_low_ff  <= '0;
         value_high_ff <= '0;
         mask_low_ff   <= '0;
         mask_high_ff  <= '0;
         length_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mbps_pkg::REG_VALUE_LOW:  value_low_ff  <= csr_data;
            mbps_pkg::REG_VALUE_HIGH: value_high_ff <= csr_data;
            mbps_pkg::REG_MASK_LOW:   mask_low_ff   <= csr_data;
            mbps_pkg::REG_MASK_HIGH:  mask_high_ff  <= csr_data;
            mbps_pkg::REG_LENGTH:     length_ff     <= csr_data[LB-1:0];
            default: ;
         endcase
      end
   end

   assign pattern.value  = {value_high_ff, value_low_ff};
   assign pattern.mask   = {mask_high_ff, mask_low_ff};
   assign pattern.length = length_ff;

   // Handshake: take a byte whenever the output register is free or drains now
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Shifted window with the incoming byte at slot 0
   always_comb begin
      window_in[0] = req_data.data_byte;
      for (int k = 1; k < PATTERN_BYTES; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   // Saturating byte count including this byte
   assign total = (&seen_ff) ? seen_ff : seen_ff + OFFSET_BITS'(1);

   mbps_window_match #(
      .PATTERN_BYTES(PATTERN_BYTES)
   ) u_match (
      .window_bytes(window_in),
      .pattern     (pattern),
      .hit         (hit)
   );

   assign start      = total - OFFSET_BITS'(length_ff);
   assign start_wide = {{OB{1'b0}}, start};

   // Result and region state update
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      found_in     = found_ff;
      seen_in      = seen_ff;
      if (accept) begin
         seen_in = total;
         if (!found_ff) begin
            if (hit && (total >= OFFSET_BITS'(length_ff))) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.found        = 1'b1;
               rsp_data_in.match_offset = start_wide[OB-1:0];
               found_in                 = 1'b1;
            end else if (req_data.last_byte) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.found        = 1'b0;
               rsp_data_in.match_offset = '0;
            end
         end
         // End of region: back to a clean window
         if (req_data.last_byte) begin
            seen_in  = '0;
            found_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         seen_ff      <= '0;
         found_ff     <= 1'b0;
         for (int k = 0; k < PATTERN_BYTES; k++) begin
            window_ff[k] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         seen_ff      <= seen_in;
         found_ff     <= found_in;
         if (accept) begin
            for (int k = 0; k < PATTERN_BYTES; k++) begin
               window_ff[k] <= req_data.last_byte ? '0 : window_in[k];
            end
         end
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- dv/masked_byte_pattern_search_core_tb.sv -----
module masked_byte_pattern_search_core_tb;

   localparam int HOLD_CYCLES   = 60;
   localparam int RANDOM_ITEMS  = 1430;
   localparam int SETTLE_CYCLES = 4;
   localparam int IDLE_PERCENT  = 20;

   logic                                clock     = 1'b0;
   logic                                reset     = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   mbps_pkg::req_type                   req_data  = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   mbps_pkg::rsp_type                   rsp_data;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [mbps_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [mbps_pkg::CSR_DATA_BITS-1:0]  csr_data  = '0;

   // Local copy of the pattern set-up
   logic [mbps_pkg::BYTE_BITS-1:0]      pat_value [mbps_pkg::PATTERN_MAX];
   logic [mbps_pkg::BYTE_BITS-1:0]      pat_mask  [mbps_pkg::PATTERN_MAX];
   logic [mbps_pkg::LENGTH_BITS-1:0]    pat_len;

   // Local copy of the scan state
   logic [mbps_pkg::BYTE_BITS-1:0]      win_bytes [mbps_pkg::PATTERN_MAX];
   logic [mbps_pkg::MATCH_OFS_BITS-1:0] seen_count;
   logic                                hit_done;

   // Scan outcomes still to come out of the rsp_ channel
   mbps_pkg::rsp_type pending_scans [$];

   bit src_idle_on  = 1'b0;
   bit sink_idle_on = 1'b0;
   bit hold_req     = 1'b0;
   int hold_left    = 0;

   int error_count  = 0;
   int region_count = 0;
   int found_count  = 0;
   int missed_count = 0;
   int csr_writes   = 0;
   int random_items = 0;

   masked_byte_pattern_search_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic void clear_region();
      foreach (win_bytes[i]) win_bytes[i] = '0;
      seen_count = '0;
      hit_done   = 1'b0;
   endfunction

   function automatic void apply_csr(input logic [mbps_pkg::CSR_INDEX_BITS-1:0] idx,
                                     input logic [mbps_pkg::CSR_DATA_BITS-1:0] val);
      case (idx)
         mbps_pkg::REG_VALUE_LOW: begin
            for (int i = 0; i < 8; i++) pat_value[i] = val[8*i +: 8];
         end
         mbps_pkg::REG_VALUE_HIGH: begin
            for (int i = 0; i < 8; i++) pat_value[8+i] = val[8*i +: 8];
         end
         mbps_pkg::REG_MASK_LOW: begin
            for (int i = 0; i < 8; i++) pat_mask[i] = val[8*i +: 8];
         end
         mbps_pkg::REG_MASK_HIGH: begin
            for (int i = 0; i < 8; i++) pat_mask[8+i] = val[8*i +: 8];
         end
         mbps_pkg::REG_LENGTH: begin
            pat_len = val[mbps_pkg::LENGTH_BITS-1:0];
         end
         default: ;
      endcase
   endfunction

   // Shifts one region byte into the window; returns 1 when it yields a result
   function automatic bit scan_byte(input mbps_pkg::req_type item,
                                    output mbps_pkg::rsp_type res);
      logic [mbps_pkg::MATCH_OFS_BITS-1:0] total;
      bit                                  hit;
      bit                                  gives;
      gives = 1'b0;
      res   = '0;
      for (int i = mbps_pkg::PATTERN_MAX - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
      win_bytes[0] = item.data_byte;
      // byte count saturates at its top value
      total = (seen_count != '1) ? seen_count + 1'b1 : seen_count;
      if (!hit_done) begin
         hit = (pat_len != 0) && (pat_len <= mbps_pkg::PATTERN_MAX) && (total >= pat_len);
         // pattern byte 0 lines up with the oldest byte of the window span
         for (int i = 0; i < mbps_pkg::PATTERN_MAX; i++) begin
            if (hit && i < pat_len) begin
               if ((win_bytes[pat_len - 1 - i] & pat_mask[i]) !=
                   (pat_value[i] & pat_mask[i])) hit = 1'b0;
            end
         end
         if (hit) begin
            res.found        = 1'b1;
            res.match_offset = total - pat_len;
            hit_done         = 1'b1;
            gives            = 1'b1;
         end else if (item.last_byte) begin
            gives = 1'b1;
         end
      end
      seen_count = total;
      if (item.last_byte) clear_region();
      return gives;
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Offers one region byte and waits for its transaction; entered at a falling edge
   task automatic send_byte(input logic [mbps_pkg::BYTE_BITS-1:0] d, input logic last);
      mbps_pkg::req_type item;
      mbps_pkg::rsp_type res;
      item.data_byte = d;
      item.last_byte = last;
      while (src_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (scan_byte(item, res)) pending_scans = {pending_scans, res};
      if (last) region_count++;
      @(negedge clock);
   endtask

   task automatic send_region(input logic [mbps_pkg::BYTE_BITS-1:0] region_bytes [$]);
      foreach (region_bytes[i]) send_byte(region_bytes[i], i == region_bytes.size() - 1);
   endtask

   // Lets the core go idle: all results out, then a short settle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_scans.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [mbps_pkg::CSR_INDEX_BITS-1:0] idx,
                                 input logic [mbps_pkg::CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, val);
      csr_writes++;
      @(negedge clock);
   endtask

   task automatic load_pattern(input logic [mbps_pkg::PATTERN_WORD-1:0] value,
                               input logic [mbps_pkg::PATTERN_WORD-1:0] mask,
                               input logic [mbps_pkg::LENGTH_BITS-1:0] len);
      wait_quiet();
      write_register(mbps_pkg::REG_VALUE_LOW,  value[63:0]);
      write_register(mbps_pkg::REG_VALUE_HIGH, value[127:64]);
      write_register(mbps_pkg::REG_MASK_LOW,   mask[63:0]);
      write_register(mbps_pkg::REG_MASK_HIGH,  mask[127:64]);
      write_register(mbps_pkg::REG_LENGTH,
                     {{(mbps_pkg::CSR_DATA_BITS-mbps_pkg::LENGTH_BITS){1'b0}}, len});
      csr_valid <= 1'b0;
   endtask

   // Receiver: random stalls, or a long hold when asked for one
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= sink_idle_on && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : check_results
      mbps_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_scans.size() == 0) begin
            report_mismatch("result with no scan outcome pending",
                            rsp_data.match_offset, 32'h0);
         end else begin
            want = pending_scans.pop_front();
            if (rsp_data.found != want.found)
               report_mismatch("found flag", {31'b0, rsp_data.found}, {31'b0, want.found});
            if (rsp_data.match_offset != want.match_offset)
               report_mismatch("match offset", rsp_data.match_offset, want.match_offset);
            if (want.found) found_count++;
            else missed_count++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Zero length after reset never matches, even against a zero window
   task automatic test_reset_state();
      send_region('{8'h00, 8'h00});
      wait_quiet();
   endtask

   // Full 16-byte exact pattern, matching at offset 0 on the last byte
   task automatic test_exact_bytes();
      logic [mbps_pkg::PATTERN_WORD-1:0] value;
      logic [mbps_pkg::BYTE_BITS-1:0]    region_bytes [$];
      value = {64'h0123_4567_89AB_CDEF, 64'h8001_FE7F_00FF_A55A};
      load_pattern(value, '1, 5'd16);
      for (int i = 0; i < mbps_pkg::PATTERN_MAX; i++)
         region_bytes = {region_bytes, value[8*i +: 8]};
      send_region(region_bytes);
      wait_quiet();
   endtask

   // Nibble wildcards, odd mask bits, and silence after a match
   task automatic test_nibble_masks();
      load_pattern({112'h0, 8'hA0, 8'h05}, {112'h0, 8'hF0, 8'h0F}, 5'd2);
      send_region('{8'h12, 8'h35, 8'hA7, 8'h00});
      load_pattern({112'h0, 8'h00, 8'h5A}, {112'h0, 8'h00, 8'h5A}, 5'd2);
      send_region('{8'h00, 8'h7B, 8'h00});
      wait_quiet();
   endtask

   // Lengths beyond the window never match; length 1 with no care bits always does
   task automatic test_length_limits();
      load_pattern('0, '0, 5'd17);
      send_region('{8'h3C});
      load_pattern('0, '0, 5'd1);
      send_region('{8'hC3, 8'h3C});
      load_pattern('0, '0, 5'd31);
      send_region('{8'h00});
      wait_quiet();
   endtask

   // Long receiver hold while every region hits at once, so req_stall must rise
   task automatic test_back_pressure();
      load_pattern('0, '0, 5'd1);
      hold_req = 1'b1;
      for (int i = 0; i < 12; i++)
         send_region('{8'($urandom_range(255)), 8'($urandom_range(255))});
      wait_quiet();
   endtask

   task automatic random_pattern(input int phase);
      logic [mbps_pkg::PATTERN_WORD-1:0] value;
      logic [mbps_pkg::PATTERN_WORD-1:0] mask;
      logic [mbps_pkg::LENGTH_BITS-1:0]  len;
      int                                pick;
      value = {$urandom, $urandom, $urandom, $urandom};
      for (int i = 0; i < mbps_pkg::PATTERN_MAX; i++) begin
         pick = $urandom_range(99);
         if (pick < 50)      mask[8*i +: 8] = 8'hFF;
         else if (pick < 65) mask[8*i +: 8] = 8'h0F;
         else if (pick < 80) mask[8*i +: 8] = 8'hF0;
         else if (pick < 90) mask[8*i +: 8] = 8'h00;
         else                mask[8*i +: 8] = 8'($urandom_range(255));
      end
      pick = $urandom_range(99);
      if (pick < 5)       len = 5'd0;
      else if (pick < 10) len = 5'($urandom_range(31, 17));
      else if (pick < 20) len = 5'd16;
      else                len = 5'($urandom_range(8, 1));
      // first two phases pin the register extremes
      if (phase == 0) begin
         value = '1;
         mask  = '1;
         len   = 5'd16;
      end else if (phase == 1) begin
         value = '0;
         mask  = '0;
         len   = 5'd1;
      end
      load_pattern(value, mask, len);
   endtask

   // Random region, mostly with the pattern planted and wildcard bits filled at random
   task automatic random_region();
      logic [mbps_pkg::BYTE_BITS-1:0] region_bytes [$];
      int                             rlen;
      int                             start;
      rlen = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(24, 1);
      for (int i = 0; i < rlen; i++)
         region_bytes = {region_bytes, 8'($urandom_range(255))};
      if (pat_len != 0 && pat_len <= mbps_pkg::PATTERN_MAX && rlen >= pat_len &&
          $urandom_range(99) < 75) begin
         start = $urandom_range(rlen - pat_len, 0);
         for (int i = 0; i < pat_len; i++)
            region_bytes[start+i] = (pat_value[i] & pat_mask[i]) |
                                    (region_bytes[start+i] & ~pat_mask[i]);
      end
      send_region(region_bytes);
      random_items += rlen;
   endtask

   task automatic test_random_regions();
      int phase;
      int n_regions;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         random_pattern(phase);
         // one phase runs flat out on both sides
         src_idle_on  = (phase != 3);
         sink_idle_on = (phase != 3);
         n_regions    = $urandom_range(12, 6);
         repeat (n_regions) random_region();
         phase++;
      end
      src_idle_on  = 1'b1;
      sink_idle_on = 1'b1;
      wait_quiet();
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      foreach (pat_value[i]) begin
         pat_value[i] = '0;
         pat_mask[i]  = '0;
      end
      pat_len = '0;
      clear_region();
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      src_idle_on  = 1'b1;
      sink_idle_on = 1'b1;
      test_reset_state();
      test_exact_bytes();
      test_nibble_masks();
      test_length_limits();
      test_back_pressure();
      test_random_regions();
      repeat (8) @(negedge clock);
      $display("Covered %0d regions under %0d register writes, incl. a long receiver hold",
               region_count, csr_writes);
      $display("Checked %0d match and %0d no-match results, %0d mismatches",
               found_count, missed_count, error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
